@@ rtl/fractional_delay_line_core_assert.svh @@
// Assertion macros used by the fractional delay line core.
// Uses clk and rst_n from the including module's scope.
`ifndef FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH
`define FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH

// same-cycle implication
`define FDL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdl: same-cycle check failed");

// next-cycle implication
`define FDL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdl: next-cycle check failed");

`endif

@@ rtl/fdl_pkg.sv @@
// Types and constants for the fractional delay line.
// No dependencies.
`default_nettype none

package fdl_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DELAY_W     = 18;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic
    {
        PH_FIRST  = 1'b0,
        PH_SECOND = 1'b1
    } phase_t;

endpackage

`default_nettype wire

@@ rtl/fractional_delay_line_core.sv @@
// Channel   | dir | handshake            | payload
// input     | in  | in_valid / in_ready  | opcode, channel, sample_in, delay
// output    | out | out_valid / out_ready| delayed_sample
//
// A push writes the store from the address stage; a read makes two store reads, one per
// phase, through the single read port, then passes the multiply and sum stages to the queue.
// Store contents are not cleared: per-channel write index and wrap flag mark unwritten
// slots, which read as zero, so the block is ready straight after reset.
// Up to four results are buffered; reads hold in the address stage when none is free.
// Depends on fdl_pkg, fdl_ram and fractional_delay_line_core_assert.svh.
`default_nettype none

module fractional_delay_line_core #(
    parameter int CHANNELS  = 2,
    parameter int DEPTH     = 1024,
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic        channel,
    input  wire logic [15:0] sample_in,
    input  wire logic [17:0] delay,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      delayed_sample
);

`include "fractional_delay_line_core_assert.svh"

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_DEPTH = CHANNELS * DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int FR_W      = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int EW        = (IDX_W + FRAC_BITS + 1 > fdl_pkg::DELAY_W) ?
                               IDX_W + FRAC_BITS + 1 : fdl_pkg::DELAY_W;
    localparam int PROD_W    = FR_W + 1 + fdl_pkg::DIFF_W;
    localparam logic [EW-1:0] SPAN  = EW'(DEPTH) << FRAC_BITS;
    localparam logic [EW-1:0] FMASK = (EW'(1) << FRAC_BITS) - EW'(1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // address stage (input register)
    logic                      s0_valid_reg;
    fdl_pkg::op_t              s0_op_reg;
    logic                      s0_ch_reg;
    fdl_pkg::sample_t          s0_sample_reg;
    logic [fdl_pkg::DELAY_W-1:0] s0_delay_reg;
    fdl_pkg::phase_t           phase_reg, phase_next;

    logic [IDX_W-1:0] wr_idx_reg [CHANNELS];
    logic             wrapped_reg [CHANNELS];

    logic [fdl_pkg::QCNT_W-1:0] credit_reg, credit_next;

    // second read cycle
    logic [RAM_AW-1:0] i2addr_reg;
    logic [FR_W-1:0]   frac_b_reg;
    logic              v1_b_reg, v2_b_reg, zero_b_reg;

    // difference / multiply stage
    logic              c_valid_reg;
    fdl_pkg::sample_t  s1_c_reg;
    logic [FR_W-1:0]   frac_c_reg;
    logic              v2_c_reg, zero_c_reg;

    // sum stage
    logic                     d_valid_reg;
    fdl_pkg::sample_t         s1_d_reg;
    logic signed [PROD_W-1:0] prod_d_reg;
    logic                     zero_d_reg;

    // result queue
    fdl_pkg::sample_t           queue_reg [fdl_pkg::QUEUE_DEPTH];
    logic [fdl_pkg::QPTR_W-1:0] qwr_reg, qrd_reg;
    logic [fdl_pkg::QCNT_W-1:0] qcnt_reg;

    logic                       in_xfer, out_xfer;
    logic                       is_read, ch_ok, s0_done, rd_start, ram_we;
    logic [CH_W-1:0]            ch_idx;
    logic [IDX_W-1:0]           wr_cur, i1, i2, wr_inc;
    logic [EW-1:0]              dly_e, dly_sat, wpos, pos;
    logic [FR_W-1:0]            frac;
    logic [RAM_AW-1:0]          base, waddr, raddr, i1addr, i2addr;
    fdl_pkg::sample_t           rdata, s2m, res;
    logic signed [fdl_pkg::DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0]   prod, shifted;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign in_ready = !s0_valid_reg || s0_done;

    assign is_read = (s0_op_reg == fdl_pkg::OP_READ);
    assign ch_ok   = (32'(s0_ch_reg) < 32'(CHANNELS));
    assign ch_idx  = ch_ok ? CH_W'(s0_ch_reg) : '0;
    assign wr_cur  = wr_idx_reg[ch_idx];
    assign wr_inc  = (wr_cur == LAST_IDX) ? '0 : wr_cur + IDX_W'(1);

    // read position
    always_comb
    begin
        dly_e   = EW'(s0_delay_reg);
        dly_sat = (dly_e >= SPAN) ? SPAN - EW'(1) : dly_e;
        wpos    = EW'(wr_cur) << FRAC_BITS;
        pos     = (wpos >= dly_sat) ? wpos - dly_sat : wpos + SPAN - dly_sat;
        i1      = IDX_W'(pos >> FRAC_BITS);
        i2      = (i1 == LAST_IDX) ? '0 : i1 + IDX_W'(1);
        frac    = FR_W'(pos & FMASK);
        base    = RAM_AW'(ch_idx) * RAM_AW'(DEPTH);
        waddr   = base + RAM_AW'(wr_cur);
        i1addr  = base + RAM_AW'(i1);
        i2addr  = base + RAM_AW'(i2);
    end

    // phase sequencer: next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            fdl_pkg::PH_FIRST:
            begin
                if (rd_start)
                begin
                    phase_next = fdl_pkg::PH_SECOND;
                end
            end
            fdl_pkg::PH_SECOND:
            begin
                phase_next = fdl_pkg::PH_FIRST;
            end
            default:
            begin
                phase_next = fdl_pkg::PH_FIRST;
            end
        endcase
    end

    // phase sequencer: outputs
    always_comb
    begin
        s0_done  = 1'b0;
        rd_start = 1'b0;
        ram_we   = 1'b0;
        raddr    = i1addr;
        unique case (phase_reg)
            fdl_pkg::PH_FIRST:
            begin
                s0_done  = s0_valid_reg && !is_read;
                rd_start = s0_valid_reg && is_read && (credit_reg != '0);
                ram_we   = s0_valid_reg && !is_read && ch_ok;
            end
            fdl_pkg::PH_SECOND:
            begin
                s0_done = 1'b1;
                raddr   = i2addr_reg;
            end
            default:
            begin
                s0_done = 1'b0;
            end
        endcase
    end

    assign credit_next = credit_reg - fdl_pkg::QCNT_W'(rd_start)
                                    + fdl_pkg::QCNT_W'(out_xfer);

    fdl_ram #(
        .WIDTH (fdl_pkg::SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (s0_sample_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            phase_reg    <= fdl_pkg::PH_FIRST;
            credit_reg   <= fdl_pkg::QCNT_W'(fdl_pkg::QUEUE_DEPTH);
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            qwr_reg      <= '0;
            qrd_reg      <= '0;
            qcnt_reg     <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                wr_idx_reg[c]  <= '0;
                wrapped_reg[c] <= 1'b0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            credit_reg  <= credit_next;
            c_valid_reg <= (phase_reg == fdl_pkg::PH_SECOND);
            d_valid_reg <= c_valid_reg;
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (ram_we)
            begin
                wr_idx_reg[ch_idx] <= wr_inc;
                if (wr_cur == LAST_IDX)
                begin
                    wrapped_reg[ch_idx] <= 1'b1;
                end
            end
            if (d_valid_reg)
            begin
                qwr_reg <= qwr_reg + fdl_pkg::QPTR_W'(1);
            end
            if (out_xfer)
            begin
                qrd_reg <= qrd_reg + fdl_pkg::QPTR_W'(1);
            end
            qcnt_reg <= qcnt_reg + fdl_pkg::QCNT_W'(d_valid_reg)
                                 - fdl_pkg::QCNT_W'(out_xfer);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s0_op_reg     <= fdl_pkg::op_t'(opcode);
            s0_ch_reg     <= channel;
            s0_sample_reg <= fdl_pkg::sample_t'(sample_in);
            s0_delay_reg  <= delay;
        end
        if (rd_start)
        begin
            i2addr_reg <= i2addr;
            frac_b_reg <= frac;
            v1_b_reg   <= wrapped_reg[ch_idx] || (i1 < wr_cur);
            v2_b_reg   <= wrapped_reg[ch_idx] || (i2 < wr_cur);
            zero_b_reg <= !ch_ok;
        end
        if (phase_reg == fdl_pkg::PH_SECOND)
        begin
            s1_c_reg   <= v1_b_reg ? rdata : '0;
            frac_c_reg <= frac_b_reg;
            v2_c_reg   <= v2_b_reg;
            zero_c_reg <= zero_b_reg;
        end
        if (c_valid_reg)
        begin
            s1_d_reg   <= s1_c_reg;
            prod_d_reg <= prod;
            zero_d_reg <= zero_c_reg;
        end
        if (d_valid_reg)
        begin
            queue_reg[qwr_reg] <= res;
        end
    end

    // interpolation: diff * frac, then floor shift and add
    always_comb
    begin
        s2m     = v2_c_reg ? rdata : '0;
        diff    = {s2m[fdl_pkg::SAMPLE_W-1], s2m} - {s1_c_reg[fdl_pkg::SAMPLE_W-1], s1_c_reg};
        prod    = $signed({1'b0, frac_c_reg}) * diff;
        shifted = prod_d_reg >>> FRAC_BITS;
        res     = zero_d_reg ? '0 : s1_d_reg + fdl_pkg::sample_t'(shifted);
    end

    assign out_valid      = (qcnt_reg != '0);
    assign delayed_sample = queue_reg[qrd_reg];

    `FDL_ASSERT_IMP(a_credit_balance, 1'b1,
        (4'(credit_reg) + 4'(qcnt_reg) + 4'(phase_reg == fdl_pkg::PH_SECOND)
         + 4'(c_valid_reg) + 4'(d_valid_reg)) == 4'(fdl_pkg::QUEUE_DEPTH))
    `FDL_ASSERT_IMP(a_queue_room, d_valid_reg,
        qcnt_reg < fdl_pkg::QCNT_W'(fdl_pkg::QUEUE_DEPTH))
    `FDL_ASSERT_NXT(a_second_read, rd_start, phase_reg == fdl_pkg::PH_SECOND)
    `FDL_ASSERT_IMP(a_no_write_mid_read, phase_reg == fdl_pkg::PH_SECOND, !ram_we)
    `FDL_ASSERT_NXT(a_sum_follows, c_valid_reg, d_valid_reg)

endmodule

`default_nettype wire

@@ rtl/fdl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fdl_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
